>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL of the conditional-execute block control.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define ASSERT_CLKRST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Default form: block clock clk_i and reset rst_ni.
`define ASSERT_DEF(label, prop, msg) \
  `ASSERT_CLKRST(label, clk_i, rst_ni, prop, msg)

`endif

>>> hdl/cexb_pkg.sv
// Package for the conditional-execute block control: request/response types,
// function and condition codes, flag bit positions. No dependencies.
`default_nettype none

package cexb_pkg;

  // Width of the remaining-count registers (counts 0 to 7).
  localparam int CountBits = 3;

  typedef logic [CountBits-1:0] cnt_t;

  // Request function codes; code 3 has no meaning and is ignored.
  typedef enum logic [1:0] {
    FuncStart = 2'd0,
    FuncStep  = 2'd1,
    FuncClear = 2'd2
  } func_e;

  typedef enum logic [3:0] {
    CondEq    = 4'd0,
    CondNe    = 4'd1,
    CondCs    = 4'd2,
    CondCc    = 4'd3,
    CondMi    = 4'd4,
    CondPl    = 4'd5,
    CondVs    = 4'd6,
    CondVc    = 4'd7,
    CondHi    = 4'd8,
    CondLs    = 4'd9,
    CondGe    = 4'd10,
    CondLt    = 4'd11,
    CondGt    = 4'd12,
    CondLe    = 4'd13,
    CondAl    = 4'd14,
    CondNever = 4'd15
  } cond_e;

  // Status flag bit positions.
  localparam int FlagC = 0;
  localparam int FlagZ = 1;
  localparam int FlagN = 2;
  localparam int FlagV = 3;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] cond_code;
    logic [2:0] true_count;
    logic [2:0] false_count;
    logic [3:0] status_flags;
  } req_t;

  typedef struct packed {
    logic bubble;
    logic cond_taken;
    logic block_active;
  } rsp_t;

  // Current control state as seen by the rest of the block.
  typedef struct packed {
    logic taken;
    logic active;
  } ctrl_stat_t;

endpackage

`default_nettype wire

>>> hdl/cexb_cond_eval.sv
// Condition evaluator: one of sixteen condition codes against the C/Z/N/V flags.
// Depends on cexb_pkg.
`default_nettype none

module cexb_cond_eval (
  input  wire logic [3:0] cond_code_i,
  input  wire logic [3:0] flags_i,
  output logic            cond_true_o
);

  logic c, z, n, v;

  assign c = flags_i[cexb_pkg::FlagC];
  assign z = flags_i[cexb_pkg::FlagZ];
  assign n = flags_i[cexb_pkg::FlagN];
  assign v = flags_i[cexb_pkg::FlagV];

  always_comb begin
    case (cexb_pkg::cond_e'(cond_code_i))
      cexb_pkg::CondEq:    cond_true_o = z;
      cexb_pkg::CondNe:    cond_true_o = ~z;
      cexb_pkg::CondCs:    cond_true_o = c;
      cexb_pkg::CondCc:    cond_true_o = ~c;
      cexb_pkg::CondMi:    cond_true_o = n;
      cexb_pkg::CondPl:    cond_true_o = ~n;
      cexb_pkg::CondVs:    cond_true_o = v;
      cexb_pkg::CondVc:    cond_true_o = ~v;
      cexb_pkg::CondHi:    cond_true_o = c & ~z;
      cexb_pkg::CondLs:    cond_true_o = ~c | z;   // carry clear or zero set
      cexb_pkg::CondGe:    cond_true_o = ~(n ^ v);
      cexb_pkg::CondLt:    cond_true_o = n ^ v;
      cexb_pkg::CondGt:    cond_true_o = ~z & ~(n ^ v);
      cexb_pkg::CondLe:    cond_true_o = z | (n ^ v);
      cexb_pkg::CondAl:    cond_true_o = 1'b1;
      cexb_pkg::CondNever: cond_true_o = 1'b0;
      default:             cond_true_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/cexb_ctrl.sv
// Control state: stored outcome and true/false remaining counts, per-request
// update and response. Depends on cexb_pkg.
`default_nettype none

module cexb_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_en_i,
  input  wire cexb_pkg::req_t       req_i,
  input  wire logic                 cond_true_i,
  output cexb_pkg::rsp_t            rsp_o,
  output cexb_pkg::ctrl_stat_t      stat_o
);

  logic             taken_q, taken_d;
  cexb_pkg::cnt_t   true_left_q, true_left_d;
  cexb_pkg::cnt_t   false_left_q, false_left_d;
  logic             bubble;

  always_comb begin
    taken_d      = taken_q;
    true_left_d  = true_left_q;
    false_left_d = false_left_q;
    bubble       = 1'b0;
    case (cexb_pkg::func_e'(req_i.func))
      cexb_pkg::FuncStart: begin
        taken_d      = cond_true_i;
        true_left_d  = cexb_pkg::cnt_t'(req_i.true_count);
        false_left_d = cexb_pkg::cnt_t'(req_i.false_count);
      end
      cexb_pkg::FuncStep: begin
        // true part drains first, then the false part
        if (true_left_q != '0) begin
          true_left_d = true_left_q - cexb_pkg::cnt_t'(1);
          bubble      = ~taken_q;
        end else if (false_left_q != '0) begin
          false_left_d = false_left_q - cexb_pkg::cnt_t'(1);
          bubble       = taken_q;
        end
      end
      cexb_pkg::FuncClear: begin
        true_left_d  = '0;
        false_left_d = '0;
      end
      default: ;
    endcase
  end

  assign rsp_o.bubble       = bubble;
  assign rsp_o.cond_taken   = taken_d;
  assign rsp_o.block_active = (true_left_d != '0) || (false_left_d != '0);

  assign stat_o.taken  = taken_q;
  assign stat_o.active = (true_left_q != '0) || (false_left_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q      <= 1'b0;
      true_left_q  <= '0;
      false_left_q <= '0;
    end else if (step_en_i) begin
      taken_q      <= taken_d;
      true_left_q  <= true_left_d;
      false_left_q <= false_left_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/conditional_execute_block_control_unit.sv
// Top level of the conditional-execute block control: request register,
// control state update and response register. Depends on cexb_pkg,
// cexb_cond_eval, cexb_ctrl and assert_macros.svh.
//
//   channel  | valid       | stall       | payload
//   ---------+-------------+-------------+------------------------
//   request  | in_valid_i  | in_stall_o  | in_req_i   (req_t)
//   response | out_valid_o | out_stall_i | out_rsp_o  (rsp_t)
//
// One request per clock while out_stall_i is low; each request yields exactly
// one response. Request register, then response register; the state update
// (condition select and one count decrement) sits between them.
// Reset clears both valid bits and the stored outcome and counts.
// A stalled response holds its register; the request register still takes a
// new request while it is empty or the response register can drain.
`default_nettype none
`include "assert_macros.svh"

module conditional_execute_block_control_unit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire cexb_pkg::req_t  in_req_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output cexb_pkg::rsp_t       out_rsp_o
);

  // Request register stage
  logic            in_valid_q;
  cexb_pkg::req_t  in_req_q;

  // Response register stage
  logic            out_valid_q;
  cexb_pkg::rsp_t  out_rsp_q;

  logic                  out_ready;  // response register can load
  logic                  step_en;    // request in stage moves to response
  logic                  cond_true;
  cexb_pkg::rsp_t        rsp;
  cexb_pkg::ctrl_stat_t  stat;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign step_en    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  cexb_cond_eval u_cond_eval (
    .cond_code_i (in_req_q.cond_code),
    .flags_i     (in_req_q.status_flags),
    .cond_true_o (cond_true)
  );

  cexb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (step_en),
    .req_i       (in_req_q),
    .cond_true_i (cond_true),
    .rsp_o       (rsp),
    .stat_o      (stat)
  );

  // Request register: loads whenever it is not holding a blocked request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_req_q <= in_req_i;
    end
  end

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      out_rsp_q <= rsp;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic clear_fire;
  logic start_fire;
  logic start_nonzero;
  logic start_open;
  logic block_off;
  logic step_idle;

  assign clear_fire    = step_en && (in_req_q.func == cexb_pkg::FuncClear);
  assign start_fire    = step_en && (in_req_q.func == cexb_pkg::FuncStart);
  assign start_nonzero = (cexb_pkg::cnt_t'(in_req_q.true_count) != '0) ||
                         (cexb_pkg::cnt_t'(in_req_q.false_count) != '0);
  assign start_open    = start_fire && start_nonzero;
  assign block_off     = !out_rsp_q.block_active && !stat.active;
  // step taken while no block is open
  assign step_idle     = step_en && !stat.active;

  // A clear leaves the block inactive in both the response and the state.
  `ASSERT_DEF(a_clear_ends_block, clear_fire |=> block_off, "clear did not end the block")
  // A start with any nonzero count opens an active block.
  `ASSERT_DEF(a_start_opens_block, start_open |=> out_rsp_q.block_active, "start left no block")
  // A bubble is only produced from a block that was active.
  `ASSERT_DEF(a_bubble_needs_block, step_idle |=> !out_rsp_q.bubble, "bubble with no block")

endmodule

`default_nettype wire

>>> tb/sv/tb_conditional_execute_block_control_unit.sv
// Self-checking testbench for conditional_execute_block_control_unit: drives
// start/step/clear requests and predicts every response. Depends on cexb_pkg.
module tb_conditional_execute_block_control_unit;

  // Code 3 of the function field has no meaning; the block must ignore it.
  localparam logic [1:0] FuncUnused = 2'd3;
  // Cycles with no accepted request or response before the run is abandoned.
  localparam int WatchdogLimit = 2000;
  // Latency is two register stages; keep draining after the expected queue empties.
  localparam int DrainCycles = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  cexb_pkg::req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  cexb_pkg::rsp_t out_rsp_o;

  // Idling on both sides is enabled per test.
  bit idle_en = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;

  // Predicted control state, mirrored from the requests that are accepted.
  logic pred_taken = 1'b0;
  cexb_pkg::cnt_t pred_true_left = '0;
  cexb_pkg::cnt_t pred_false_left = '0;
  cexb_pkg::rsp_t expected_ctrl_q[$];

  int n_sent = 0;
  int n_checked = 0;
  int n_bubbles = 0;
  int n_starts = 0;
  int n_errors = 0;

  conditional_execute_block_control_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  always #10 clk_i = ~clk_i;

  // Condition evaluation against C, Z, N, V. LS holds on carry clear or zero set.
  function automatic logic cond_holds(cexb_pkg::cond_e cc, logic [3:0] flags);
    logic c, z, n, v;
    c = flags[cexb_pkg::FlagC];
    z = flags[cexb_pkg::FlagZ];
    n = flags[cexb_pkg::FlagN];
    v = flags[cexb_pkg::FlagV];
    case (cc)
      cexb_pkg::CondEq:  return z;
      cexb_pkg::CondNe:  return !z;
      cexb_pkg::CondCs:  return c;
      cexb_pkg::CondCc:  return !c;
      cexb_pkg::CondMi:  return n;
      cexb_pkg::CondPl:  return !n;
      cexb_pkg::CondVs:  return v;
      cexb_pkg::CondVc:  return !v;
      cexb_pkg::CondHi:  return c && !z;
      cexb_pkg::CondLs:  return !c || z;
      cexb_pkg::CondGe:  return !(n ^ v);
      cexb_pkg::CondLt:  return n ^ v;
      cexb_pkg::CondGt:  return !z && !(n ^ v);
      cexb_pkg::CondLe:  return z || (n ^ v);
      cexb_pkg::CondAl:  return 1'b1;
      default:           return 1'b0;
    endcase
  endfunction

  // Advances the mirrored state by one request and returns its response.
  function automatic cexb_pkg::rsp_t predict_control(cexb_pkg::req_t r);
    cexb_pkg::rsp_t o;
    o = '0;
    case (r.func)
      cexb_pkg::FuncStart: begin
        pred_true_left = cexb_pkg::cnt_t'(r.true_count);
        pred_false_left = cexb_pkg::cnt_t'(r.false_count);
        pred_taken = cond_holds(cexb_pkg::cond_e'(r.cond_code), r.status_flags);
      end
      cexb_pkg::FuncStep: begin
        // True part drains first; a step with both counts at zero runs as is.
        if (pred_true_left != '0) begin
          pred_true_left = pred_true_left - cexb_pkg::cnt_t'(1);
          o.bubble = !pred_taken;
        end else if (pred_false_left != '0) begin
          pred_false_left = pred_false_left - cexb_pkg::cnt_t'(1);
          o.bubble = pred_taken;
        end
      end
      cexb_pkg::FuncClear: begin
        pred_true_left = '0;
        pred_false_left = '0;
      end
      default: ;
    endcase
    o.cond_taken = pred_taken;
    o.block_active = (pred_true_left != '0) || (pred_false_left != '0);
    return o;
  endfunction

  // Mostly back-to-back, sometimes a short pause, rarely a long one.
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (!idle_en || pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    n_errors++;
  endtask

  // Presents one request, holds it until taken, then optionally idles.
  task automatic send_request(logic [1:0] func, logic [3:0] cond, logic [2:0] t_cnt,
                              logic [2:0] f_cnt, logic [3:0] flags);
    cexb_pkg::req_t r;
    int gap;
    r.func = func;
    r.cond_code = cond;
    r.true_count = t_cnt;
    r.false_count = f_cnt;
    r.status_flags = flags;
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    n_sent++;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      in_req_i <= cexb_pkg::req_t'(16'($urandom()));
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Consumer side stall pattern.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      if (idle_en && $urandom_range(0, 99) < 15)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                   : $urandom_range(1, 3);
    end
  end

  // Predicts on each accepted request and checks each accepted response.
  always @(posedge clk_i) begin
    cexb_pkg::rsp_t exp_rsp;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        exp_rsp = predict_control(in_req_i);
        expected_ctrl_q.push_back(exp_rsp);
        if (exp_rsp.bubble) n_bubbles++;
        if (in_req_i.func == cexb_pkg::FuncStart) n_starts++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_ctrl_q.size() == 0) begin
          report_mismatch($sformatf("response %0d arrived with nothing outstanding",
                                    n_checked));
        end else begin
          exp_rsp = expected_ctrl_q.pop_front();
          if (out_rsp_o.bubble !== exp_rsp.bubble)
            report_mismatch($sformatf("bubble expected %0b got %0b at response %0d",
                                      exp_rsp.bubble, out_rsp_o.bubble, n_checked));
          if (out_rsp_o.cond_taken !== exp_rsp.cond_taken)
            report_mismatch($sformatf("cond_taken expected %0b got %0b at response %0d",
                                      exp_rsp.cond_taken, out_rsp_o.cond_taken, n_checked));
          if (out_rsp_o.block_active !== exp_rsp.block_active)
            report_mismatch($sformatf("block_active expected %0b got %0b at response %0d",
                                      exp_rsp.block_active, out_rsp_o.block_active,
                                      n_checked));
        end
        n_checked++;
      end
    end
  end

  // Ends a hung run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("timeout: no handshake for %0d cycles", WatchdogLimit);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Extremes, every function code, the LS condition, empty steps and ignored code 3.
  task automatic test_directed_cases();
    idle_en = 1'b0;
    send_request(cexb_pkg::FuncStep, cexb_pkg::CondEq, 3'd0, 3'd0, 4'h0);  // no block
    send_request(FuncUnused, cexb_pkg::CondNever, 3'd7, 3'd7, 4'hF);       // ignored code
    send_request(cexb_pkg::FuncStart, cexb_pkg::CondAl, 3'd7, 3'd7, 4'h0);
    repeat (3) send_request(cexb_pkg::FuncStep, cexb_pkg::CondEq, 3'd0, 3'd0, 4'h0);
    send_request(cexb_pkg::FuncClear, cexb_pkg::CondEq, 3'd7, 3'd7, 4'hF); // branch ends block
    send_request(cexb_pkg::FuncStep, cexb_pkg::CondEq, 3'd0, 3'd0, 4'h0);
    send_request(cexb_pkg::FuncStart, cexb_pkg::CondNever, 3'd1, 3'd2, 4'hF);
    repeat (4) send_request(cexb_pkg::FuncStep, cexb_pkg::CondAl, 3'd7, 3'd7, 4'hF);
    // LS: carry clear or zero set
    send_request(cexb_pkg::FuncStart, cexb_pkg::CondLs, 3'd0, 3'd0, 4'h0);
    send_request(cexb_pkg::FuncStart, cexb_pkg::CondLs, 3'd0, 3'd0, 4'h1);
    send_request(cexb_pkg::FuncStart, cexb_pkg::CondLs, 3'd0, 3'd0, 4'h3);
    // taken block with only a false part: every step within the block bubbles
    send_request(cexb_pkg::FuncStart, cexb_pkg::CondEq, 3'd0, 3'd3, 4'h2);
    send_request(cexb_pkg::FuncStep, cexb_pkg::CondEq, 3'd0, 3'd0, 4'h0);
    send_request(FuncUnused, cexb_pkg::CondEq, 3'd0, 3'd0, 4'h0);     // must not disturb counts
    repeat (3) send_request(cexb_pkg::FuncStep, cexb_pkg::CondEq, 3'd0, 3'd0, 4'h0);
    send_request(cexb_pkg::FuncStart, cexb_pkg::CondNe, 3'd7, 3'd0, 4'h0);
  endtask

  // Every condition against every flag combination.
  task automatic test_condition_sweep();
    idle_en = 1'b1;
    for (int c = 0; c <= int'(cexb_pkg::CondNever); c++)
      for (int f = 0; f < (1 << 4); f++)
        send_request(cexb_pkg::FuncStart, 4'(c), 3'($urandom()), 3'($urandom()), 4'(f));
  endtask

  // Well-formed blocks with random content, plus clears and noise.
  task automatic test_random_blocks(int n_blocks, bit with_idle);
    int len, pick, k;
    logic [2:0] t_cnt, f_cnt;
    idle_en = with_idle;
    for (int b = 0; b < n_blocks; b++) begin
      t_cnt = 3'($urandom());
      f_cnt = 3'($urandom());
      send_request(cexb_pkg::FuncStart, 4'($urandom()), t_cnt, f_cnt, 4'($urandom()));
      len = int'(t_cnt) + int'(f_cnt);
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        // full block, sometimes overrunning it
        k = len + $urandom_range(0, 2);
        repeat (k) send_request(cexb_pkg::FuncStep, 4'($urandom()), 3'($urandom()),
                                3'($urandom()), 4'($urandom()));
      end else if (pick < 8) begin
        // branch taken partway through
        k = (len > 0) ? $urandom_range(0, len - 1) : 0;
        repeat (k) send_request(cexb_pkg::FuncStep, 4'($urandom()), 3'($urandom()),
                                3'($urandom()), 4'($urandom()));
        send_request(cexb_pkg::FuncClear, 4'($urandom()), 3'($urandom()), 3'($urandom()),
                     4'($urandom()));
      end else begin
        // any function code, including the ignored one
        k = $urandom_range(1, 10);
        repeat (k) send_request(2'($urandom()), 4'($urandom()), 3'($urandom()), 3'($urandom()),
                                4'($urandom()));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_condition_sweep();
    test_random_blocks(22, 1'b1);
    test_random_blocks(6, 1'b0);

    in_valid_i <= 1'b0;
    idle_en = 1'b0;
    while (expected_ctrl_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_ctrl_q.size() != 0) begin
      report_mismatch($sformatf("%0d responses never arrived", expected_ctrl_q.size()));
    end

    $display("sent %0d requests (%0d block starts), checked %0d responses", n_sent, n_starts,
             n_checked);
    $display("%0d bubbles predicted, %0d mismatches", n_bubbles, n_errors);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
